### rtl/bsfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsfp_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_FRAMING = 2'd1,
        ST_CRC     = 2'd2
    } status_t;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_BYTE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_MASK = 2'd3;

    localparam logic [7:0] START_RESET = 8'h7E;
    localparam logic [7:0] END_RESET   = 8'h7F;
    localparam logic [7:0] ESC_RESET   = 8'h7D;
    localparam logic [7:0] MASK_RESET  = 8'h20;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_MSB  = 8'h80;
    localparam logic [7:0] CRC_INIT = 8'h00;

    localparam int OUT_DATA_W = 64;

    // One closed frame, handed from the front to the back.
    typedef struct packed {
        status_t    status;
        logic [7:0] cmd;
        logic [7:0] len;
    } frame_evt_t;

    // Back-to-front control: store read port and release of the store.
    typedef struct packed {
        logic       rd_en;
        logic [7:0] rd_addr;
        logic       done;
    } back_ctl_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                               input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != CRC_INIT) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/byte_stuffed_frame_parser_crc8.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake          | Contents
// s_      | in        | s_tvalid/s_tready  | raw link byte
// m_      | out       | m_tvalid/m_tready  | one result item, m_tlast ends a run
// cfg_    | in        | cfg_valid/cfg_ready| register index and 8-bit value
//
// Link bytes are taken one per cycle unless stalled; stored bytes after the
// length update the CRC on the fly. Each payload item of a good frame takes a
// registered store read, then an output load; an error or empty frame's item
// loads as its event pops. Input stalls from a good frame's end until its
// payload has left the store, and while the two-entry event queue is full.
// Synchronous reset restores delimiters, clears only control state and counts.
module byte_stuffed_frame_parser_crc8
    import bsfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  wire  [7:0]            s_tdata,   // in_byte[7:0]
    output logic                  m_tvalid,
    input  wire                   m_tready,
    // status[1:0], command[9:2], length[15:10], byte_index[20:16],
    // payload_byte[28:21], byte_valid[29], framing_error_count[45:30],
    // crc_error_count[61:46], zero fill[63:62]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,   // last
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire  [CFG_IDX_W-1:0]  cfg_index,
    input  wire  [7:0]            cfg_data
);

    logic       q_push, q_full, q_pop, q_valid;
    frame_evt_t q_din, q_dout;
    back_ctl_t  ctl;
    logic [7:0] rd_data;

    bsfp_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_push    (q_push),
        .q_entry   (q_din),
        .q_full    (q_full),
        .ctl       (ctl),
        .rd_data   (rd_data)
    );

    bsfp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .dout    (q_dout)
    );

    bsfp_back #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (q_dout),
        .q_pop    (q_pop),
        .ctl      (ctl),
        .rd_data  (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

### rtl/bsfp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module bsfp_queue
    import bsfp_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         push,
    input  frame_evt_t  din,
    output logic        full,
    input  wire         pop,
    output logic        valid,
    output frame_evt_t  dout
);

    frame_evt_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign dout  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

`default_nettype wire

### rtl/bsfp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bsfp_front
    import bsfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire  [7:0]           s_tdata,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire  [CFG_IDX_W-1:0] cfg_index,
    input  wire  [7:0]           cfg_data,
    output logic                 q_push,
    output frame_evt_t           q_entry,
    input  wire                  q_full,
    input  back_ctl_t            ctl,
    output logic [7:0]           rd_data
);

    localparam int DEPTH = MAX_PAYLOAD + 3;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        BK_START,
        BK_IGNORE,
        BK_ESCAPE,
        BK_END,
        BK_DATA
    } byte_kind_t;

    logic [7:0]    start_reg, end_reg, esc_reg, mask_reg;
    logic          in_frame_reg;
    logic          esc_pend_reg;
    logic [FW-1:0] fill_reg;
    logic [7:0]    len_reg, cmd_reg;
    logic [7:0]    crc_reg, prev_crc_reg, last_reg;
    logic          lock_reg;
    logic [7:0]    store [DEPTH];
    logic [7:0]    rd_data_reg;

    logic          accept;
    byte_kind_t    kind;
    logic [7:0]    data_byte;
    logic          store_full;
    logic          store_wr;
    logic          restart;

    assign s_tready  = !lock_reg && !q_full;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign rd_data   = rd_data_reg;

    assign data_byte  = esc_pend_reg ? (s_tdata ^ mask_reg) : s_tdata;
    assign store_full = (fill_reg == FW'(DEPTH));

    always_comb begin
        if (!esc_pend_reg && s_tdata == start_reg) begin
            kind = BK_START;
        end else if (!in_frame_reg) begin
            kind = BK_IGNORE;
        end else if (!esc_pend_reg && s_tdata == esc_reg) begin
            kind = BK_ESCAPE;
        end else if (!esc_pend_reg && s_tdata == end_reg) begin
            kind = BK_END;
        end else begin
            kind = BK_DATA;
        end
    end

    // The running CRC covers every stored byte after the length; the value
    // before the newest byte is the check over cmd and payload once the
    // newest byte turns out to be the trailing CRC.
    always_comb begin
        q_push   = 1'b0;
        q_entry  = '{status: ST_FRAMING, cmd: 8'd0, len: 8'd0};
        store_wr = 1'b0;
        restart  = 1'b0;
        if (accept) begin
            unique case (kind)
                BK_END: begin
                    q_push  = 1'b1;
                    restart = 1'b1;
                    if (fill_reg < FW'(2)) begin
                        q_entry.status = ST_FRAMING;
                    end else if (len_reg > 8'(MAX_PAYLOAD) ||
                                 ({1'b0, len_reg} + 9'd3) != 9'(fill_reg)) begin
                        q_entry.status = ST_FRAMING;
                    end else if (prev_crc_reg != last_reg) begin
                        q_entry.status = ST_CRC;
                    end else begin
                        q_entry.status = ST_GOOD;
                        q_entry.cmd    = cmd_reg;
                        q_entry.len    = len_reg;
                    end
                end
                BK_DATA: begin
                    if (store_full) begin
                        q_push  = 1'b1;
                        restart = 1'b1;
                    end else begin
                        store_wr = 1'b1;
                    end
                end
                BK_START, BK_IGNORE, BK_ESCAPE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (store_wr) begin
            store[fill_reg[AW-1:0]] <= data_byte;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= store[ctl.rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg    <= START_RESET;
            end_reg      <= END_RESET;
            esc_reg      <= ESC_RESET;
            mask_reg     <= MASK_RESET;
            in_frame_reg <= 1'b0;
            esc_pend_reg <= 1'b0;
            fill_reg     <= '0;
            crc_reg      <= CRC_INIT;
            lock_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_START_BYTE:  start_reg <= cfg_data;
                    CFG_END_BYTE:    end_reg   <= cfg_data;
                    CFG_ESCAPE_BYTE: esc_reg   <= cfg_data;
                    CFG_ESCAPE_MASK: mask_reg  <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (ctl.done) begin
                lock_reg <= 1'b0;
            end else if (q_push && q_entry.status == ST_GOOD) begin
                lock_reg <= 1'b1;
            end
            if (accept) begin
                if (kind == BK_START) begin
                    in_frame_reg <= 1'b1;
                    esc_pend_reg <= 1'b0;
                    fill_reg     <= '0;
                    crc_reg      <= CRC_INIT;
                end else if (restart) begin
                    in_frame_reg <= 1'b0;
                    esc_pend_reg <= 1'b0;
                    fill_reg     <= '0;
                end else if (kind == BK_ESCAPE) begin
                    esc_pend_reg <= 1'b1;
                end else if (store_wr) begin
                    esc_pend_reg <= 1'b0;
                    fill_reg     <= fill_reg + FW'(1);
                    prev_crc_reg <= crc_reg;
                    last_reg     <= data_byte;
                    if (fill_reg == '0) begin
                        len_reg <= data_byte;
                    end else begin
                        crc_reg <= crc8_update(crc_reg, data_byte);
                    end
                    if (fill_reg == FW'(1)) begin
                        cmd_reg <= data_byte;
                    end
                end
            end
        end
    end

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full) else $error("frame event pushed into a full queue");

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(DEPTH)) else $error("fill count beyond store depth");

    a_good_locks: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push && q_entry.status == ST_GOOD |=> lock_reg)
        else $error("good frame did not lock the store");

endmodule

`default_nettype wire

### rtl/bsfp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bsfp_back
    import bsfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   q_valid,
    input  frame_evt_t            q_entry,
    output logic                  q_pop,
    output back_ctl_t             ctl,
    input  wire  [7:0]            rd_data,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    localparam int IW = $clog2(MAX_PAYLOAD + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_WR
    } state_t;

    state_t        state_reg;
    logic [7:0]    cmd_reg, len_reg;
    logic [IW-1:0] idx_reg;

    logic          out_valid_reg;
    status_t       o_status_reg;
    logic [7:0]    o_cmd_reg;
    logic [5:0]    o_len_reg;
    logic [4:0]    o_idx_reg;
    logic [7:0]    o_byte_reg;
    logic          o_bvalid_reg;
    logic          o_last_reg;
    logic [15:0]   fe_reg, ce_reg;

    logic          out_free;
    logic          is_last;
    logic          direct_evt;
    logic          out_load;

    assign out_free   = !out_valid_reg || m_tready;
    assign is_last    = (8'(idx_reg) + 8'd1) == len_reg;
    assign direct_evt = (q_entry.status != ST_GOOD) || (q_entry.len == 8'd0);
    assign q_pop      = (state_reg == ST_IDLE) && q_valid && out_free;
    assign out_load   = (q_pop && direct_evt) || (state_reg == ST_WR && out_free);

    always_comb begin
        ctl.rd_en   = (state_reg == ST_RD);
        ctl.rd_addr = 8'(idx_reg) + 8'd2;
        ctl.done    = (q_pop && q_entry.status == ST_GOOD && q_entry.len == 8'd0) ||
                      (state_reg == ST_WR && out_free && is_last);
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = o_last_reg;
    // m_tdata, from bit 0: status[1:0], command[9:2], length[15:10],
    // byte_index[20:16], payload_byte[28:21], byte_valid[29],
    // framing_error_count[45:30], crc_error_count[61:46], zero fill.
    assign m_tdata  = {2'b00, ce_reg, fe_reg, o_bvalid_reg, o_byte_reg,
                       o_idx_reg, o_len_reg, o_cmd_reg, o_status_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            fe_reg        <= '0;
            ce_reg        <= '0;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        cmd_reg <= q_entry.cmd;
                        len_reg <= q_entry.len;
                        idx_reg <= '0;
                        if (direct_evt) begin
                            o_status_reg  <= q_entry.status;
                            o_cmd_reg     <= q_entry.cmd;
                            o_len_reg     <= 6'd0;
                            o_idx_reg     <= 5'd0;
                            o_byte_reg    <= 8'd0;
                            o_bvalid_reg  <= 1'b0;
                            o_last_reg    <= 1'b1;
                            if (q_entry.status == ST_FRAMING && fe_reg != 16'hFFFF) begin
                                fe_reg <= fe_reg + 16'd1;
                            end
                            if (q_entry.status == ST_CRC && ce_reg != 16'hFFFF) begin
                                ce_reg <= ce_reg + 16'd1;
                            end
                        end else begin
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_RD: begin
                    state_reg <= ST_WR;
                end
                ST_WR: begin
                    if (out_free) begin
                        o_status_reg  <= ST_GOOD;
                        o_cmd_reg     <= cmd_reg;
                        o_len_reg     <= len_reg[5:0];
                        o_idx_reg     <= 5'(idx_reg);
                        o_byte_reg    <= rd_data;
                        o_bvalid_reg  <= 1'b1;
                        o_last_reg    <= is_last;
                        idx_reg       <= idx_reg + IW'(1);
                        state_reg     <= is_last ? ST_IDLE : ST_RD;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_wr_after_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WR |-> $past(state_reg) == ST_RD || $past(state_reg) == ST_WR)
        else $error("payload write without a preceding store read");

    a_fe_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> fe_reg >= $past(fe_reg))
        else $error("framing error count decreased");

    a_payload_item_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WR && out_free |=> m_tvalid && m_tdata[29])
        else $error("payload item loaded without byte_valid");

endmodule

`default_nettype wire

### tb/byte_stuffed_frame_parser_crc8_tb.sv
`timescale 1ns / 1ps

module byte_stuffed_frame_parser_crc8_tb;
    import bsfp_pkg::*;

    localparam int MAX_PAYLOAD   = 32;
    localparam int STORE_DEPTH   = MAX_PAYLOAD + 3;
    localparam int SETTLE_CYCLES = 20;
    localparam int WD_LIMIT      = 3000;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER [4] =
        '{CFG_START_BYTE, CFG_END_BYTE, CFG_ESCAPE_BYTE, CFG_ESCAPE_MASK};

    typedef struct packed {
        status_t     status;
        logic [7:0]  command;
        logic [5:0]  length;
        logic [4:0]  byte_index;
        logic [7:0]  payload_byte;
        logic        byte_valid;
        logic        last;
        logic [15:0] framing_count;
        logic [15:0] crc_count;
    } frame_res_t;

    // One link byte, with a status verdict typed in where it is obvious.
    typedef struct packed {
        logic [7:0]  raw;
        logic        typed;
        status_t     st;
        logic [15:0] fe;
        logic [15:0] ce;
    } link_item_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = 8'h00;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_START_BYTE;
    logic [7:0]            cfg_data = 8'h00;

    link_item_t tx_tag = '0;

    // Deframer state as the checker sees it.
    logic [7:0]  reg_start, reg_end, reg_esc, reg_mask;
    logic        link_open, esc_armed;
    int          stored_n;
    logic [7:0]  frame_buf [STORE_DEPTH];
    logic [15:0] n_framing, n_crc;
    frame_res_t  exp_q [$];

    // Delimiters and escape mask the stimulus side currently encodes with.
    logic [7:0] cfg_now [4];
    logic [7:0] tx_q [$];
    link_item_t dir_tab [25];

    bit calm = 1'b0;
    int mismatches = 0;
    int idle_cycles = 0;
    int n_bytes = 0;
    int n_frames = 0;
    int n_results = 0;
    int n_settings = 0;

    byte_stuffed_frame_parser_crc8 DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [7:0] crc8_poly31(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            fb = c[7];
            c = c << 1;
            if (fb) begin
                c = c ^ 8'h31;
            end
        end
        return c;
    endfunction

    function automatic frame_res_t status_item(input status_t st, input logic [15:0] fe,
                                               input logic [15:0] ce);
        return '{st, 8'h00, 6'd0, 5'd0, 8'h00, 1'b0, 1'b1, fe, ce};
    endfunction

    function automatic void close_frame();
        link_open = 1'b0;
        esc_armed = 1'b0;
        stored_n = 0;
    endfunction

    function automatic int framing_event();
        if (n_framing != 16'hFFFF) begin
            n_framing++;
        end
        close_frame();
        exp_q.push_back(status_item(ST_FRAMING, n_framing, n_crc));
        return 1;
    endfunction

    // Advances the deframer by one link byte and queues the items it causes.
    function automatic int deframe_byte(input logic [7:0] raw);
        logic [7:0] b;
        logic [7:0] crc;
        int         len;
        b = raw;
        if (!esc_armed && b == reg_start) begin
            close_frame();
            link_open = 1'b1;
            return 0;
        end
        if (!link_open) begin
            return 0;
        end
        if (!esc_armed && b == reg_esc) begin
            esc_armed = 1'b1;
            return 0;
        end
        if (!esc_armed && b == reg_end) begin
            if (stored_n < 2) begin
                return framing_event();
            end
            len = frame_buf[0];
            if (len > MAX_PAYLOAD || stored_n != len + 3) begin
                return framing_event();
            end
            crc = crc8_poly31(8'h00, frame_buf[1]);
            for (int i = 0; i < len; i++) begin
                crc = crc8_poly31(crc, frame_buf[2 + i]);
            end
            close_frame();
            if (crc != frame_buf[2 + len]) begin
                if (n_crc != 16'hFFFF) begin
                    n_crc++;
                end
                exp_q.push_back(status_item(ST_CRC, n_framing, n_crc));
                return 1;
            end
            if (len == 0) begin
                exp_q.push_back('{ST_GOOD, frame_buf[1], 6'd0, 5'd0, 8'h00, 1'b0, 1'b1,
                                  n_framing, n_crc});
                return 1;
            end
            for (int i = 0; i < len; i++) begin
                exp_q.push_back('{ST_GOOD, frame_buf[1], 6'(len), 5'(i), frame_buf[2 + i],
                                  1'b1, (i == len - 1), n_framing, n_crc});
            end
            return len;
        end
        if (esc_armed) begin
            b = b ^ reg_mask;
            esc_armed = 1'b0;
        end
        if (stored_n >= STORE_DEPTH) begin
            return framing_event();
        end
        frame_buf[stored_n] = b;
        stored_n++;
        return 0;
    endfunction

    function automatic frame_res_t unpack_result(input logic [OUT_DATA_W-1:0] d,
                                                 input logic tl);
        frame_res_t r;
        r.status        = status_t'(d[1:0]);
        r.command       = d[9:2];
        r.length        = d[15:10];
        r.byte_index    = d[20:16];
        r.payload_byte  = d[28:21];
        r.byte_valid    = d[29];
        r.last          = tl;
        r.framing_count = d[45:30];
        r.crc_count     = d[61:46];
        return r;
    endfunction

    function automatic string describe_result(input frame_res_t r);
        return $sformatf("st=%0d cmd=%h len=%0d idx=%0d byte=%h bv=%b last=%b fe=%0d ce=%0d",
                         r.status, r.command, r.length, r.byte_index, r.payload_byte,
                         r.byte_valid, r.last, r.framing_count, r.crc_count);
    endfunction

    always @(posedge aclk) begin
        frame_res_t got;
        frame_res_t want;
        int         n;
        if (!aresetn) begin
            reg_start = START_RESET;
            reg_end   = END_RESET;
            reg_esc   = ESC_RESET;
            reg_mask  = MASK_RESET;
            close_frame();
            n_framing = 16'd0;
            n_crc     = 16'd0;
            idle_cycles = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_START_BYTE:  reg_start = cfg_data;
                    CFG_END_BYTE:    reg_end   = cfg_data;
                    CFG_ESCAPE_BYTE: reg_esc   = cfg_data;
                    CFG_ESCAPE_MASK: reg_mask  = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                n = deframe_byte(s_tdata);
                if (tx_tag.typed) begin
                    if (n != 1) begin
                        mismatches++;
                        $display("%0t: byte %h: expected one status item, predicted %0d",
                                 $time, s_tdata, n);
                    end else begin
                        void'(exp_q.pop_back());
                        exp_q.push_back(status_item(tx_tag.st, tx_tag.fe, tx_tag.ce));
                    end
                end
            end
            if (m_tvalid && m_tready) begin
                got = unpack_result(m_tdata, m_tlast);
                if (exp_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result item: expected none, actual %s",
                             $time, describe_result(got));
                end else begin
                    want = exp_q.pop_front();
                    n_results++;
                    if (got !== want) begin
                        mismatches++;
                        $display("%0t: result mismatch: expected %s, actual %s",
                                 $time, describe_result(want), describe_result(got));
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WD_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d items still expected",
                         $time, idle_cycles, exp_q.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Result side: random stalls between ready stretches while calm is clear.
    initial begin
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    function automatic link_item_t plain(input logic [7:0] b);
        return '{b, 1'b0, ST_GOOD, 16'd0, 16'd0};
    endfunction

    function automatic link_item_t judged(input logic [7:0] b, input status_t st,
                                          input logic [15:0] fe, input logic [15:0] ce);
        return '{b, 1'b1, st, fe, ce};
    endfunction

    // Biased toward the delimiters and the extremes so that stuffing is exercised.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return cfg_now[0];
            1: return cfg_now[1];
            2: return cfg_now[2];
            3: return 8'h00;
            4: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void put_stuffed(input logic [7:0] b);
        if (b == cfg_now[0] || b == cfg_now[1] || b == cfg_now[2] || $urandom_range(0, 15) == 0)
        begin
            tx_q.push_back(cfg_now[2]);
            tx_q.push_back(b ^ cfg_now[3]);
        end else begin
            tx_q.push_back(b);
        end
    endfunction

    task automatic send_item(input link_item_t tag);
        if (!calm && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tag.raw;
        tx_tag   <= tag;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_bytes++;
    endtask

    task automatic write_setting(input logic [7:0] st, input logic [7:0] en,
                                 input logic [7:0] es, input logic [7:0] mk);
        logic [7:0] v [4];
        v = '{st, en, es, mk};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= REG_ORDER[i];
            cfg_data  <= v[i];
            cfg_now[i] = v[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Mostly well-formed frames with random content; the rest are broken on purpose.
    task automatic build_frame(output int counted);
        int         kind;
        int         plen;
        int         keep;
        logic [7:0] cmd;
        logic [7:0] crc;
        logic [7:0] data [$];
        kind = $urandom_range(0, 99);
        if (kind >= 88) begin
            repeat ($urandom_range(1, 6)) tx_q.push_back(8'($urandom_range(0, 255)));
            counted = tx_q.size();
            return;
        end
        n_frames++;
        plen = ($urandom_range(0, 11) == 0) ? $urandom_range(7, MAX_PAYLOAD)
                                            : $urandom_range(0, 6);
        if ($urandom_range(0, 29) == 0) begin
            plen = MAX_PAYLOAD;
        end
        cmd = pick_byte();
        crc = crc8_poly31(8'h00, cmd);
        data.push_back(8'(plen));
        data.push_back(cmd);
        for (int i = 0; i < plen; i++) begin
            data.push_back(pick_byte());
            crc = crc8_poly31(crc, data[$]);
        end
        data.push_back(crc);
        if (kind < 55) begin
        end else if (kind < 65) begin
            data[$] = crc ^ (8'h01 << $urandom_range(0, 7));
        end else if (kind < 72) begin
            data[0] = (plen == 0 || $urandom_range(0, 1) == 1) ? 8'(plen + 1) : 8'(plen - 1);
        end else if (kind < 76) begin
            data[0] = 8'($urandom_range(MAX_PAYLOAD + 1, 255));
        end else if (kind < 80) begin
            data.delete();
            if ($urandom_range(0, 1) == 1) begin
                data.push_back(pick_byte());
            end
        end else if (kind < 85) begin
            keep = $urandom_range(1, plen + 2);
            while (data.size() > keep) void'(data.pop_back());
        end else begin
            data.delete();
            repeat ($urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 5)) data.push_back(pick_byte());
        end
        tx_q.push_back(cfg_now[0]);
        foreach (data[i]) put_stuffed(data[i]);
        // A cut-off frame has no end byte and may leave an escape hanging.
        if (kind >= 80 && kind < 85) begin
            if ($urandom_range(0, 1) == 1) begin
                tx_q.push_back(cfg_now[2]);
            end
        end else begin
            tx_q.push_back(cfg_now[1]);
        end
        counted = tx_q.size();
    endtask

    task automatic random_traffic(input int budget);
        int done_bytes;
        int counted;
        done_bytes = 0;
        while (done_bytes < budget) begin
            build_frame(counted);
            done_bytes += counted;
            while (tx_q.size() != 0) send_item(plain(tx_q.pop_front()));
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (exp_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [7:0] rs, re, rx;
        dir_tab = '{
            plain(8'h55), plain(8'h7D),
            plain(8'h7E), judged(8'h7F, ST_FRAMING, 16'd1, 16'd0),
            // One-byte payload of all ones, escaped start as command, escaped crc.
            plain(8'h7E), plain(8'h01), plain(8'h7D), plain(8'h5E), plain(8'hFF),
            plain(8'h7D), plain(crc8_poly31(crc8_poly31(8'h00, 8'h7E), 8'hFF) ^ 8'h20),
            plain(8'h7F),
            // A start byte right after an escape is stored as data.
            plain(8'h7E), plain(8'h7D), plain(8'h7E), judged(8'h7F, ST_FRAMING, 16'd2, 16'd0),
            plain(8'h7E), plain(8'h00), plain(8'h00), plain(8'h01),
            judged(8'h7F, ST_CRC, 16'd2, 16'd1),
            plain(8'h7E), plain(8'h21), plain(8'h00), judged(8'h7F, ST_FRAMING, 16'd3, 16'd1)
        };
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_setting(START_RESET, END_RESET, ESC_RESET, MASK_RESET);
        foreach (dir_tab[i]) send_item(dir_tab[i]);
        random_traffic(80);
        drain();

        write_setting(8'h00, 8'hFF, 8'h01, 8'hFF);
        random_traffic(65);
        drain();

        write_setting(8'hFF, 8'h00, 8'h80, 8'h00);
        random_traffic(65);
        drain();

        rs = 8'($urandom_range(0, 255));
        do re = 8'($urandom_range(0, 255)); while (re == rs);
        do rx = 8'($urandom_range(0, 255)); while (rx == rs || rx == re);
        write_setting(rs, re, rx, 8'($urandom_range(0, 255)));
        random_traffic(45);
        drain();

        // Escape equal to start: every escape restarts the frame.
        write_setting(8'h5A, 8'hA5, 8'h5A, 8'($urandom_range(0, 255)));
        random_traffic(25);
        drain();

        calm = 1'b1;
        write_setting(START_RESET, END_RESET, ESC_RESET, MASK_RESET);
        random_traffic(65);
        drain();

        $display("Summary: %0d link bytes in %0d frames under %0d delimiter settings",
                 n_bytes, n_frames, n_settings);
        $display("Summary: %0d result items checked, final counts %0d framing / %0d crc",
                 n_results, n_framing, n_crc);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
